>>> hdl/ssdrw_pkg.sv
// ----------------------------------------------------------------------------
// ssdrw_pkg
// Shared types, constants and character/merge functions of the segment
// memory writer.
// ----------------------------------------------------------------------------
package ssdrw_pkg;

    localparam int DIGIT_COUNT      = 26;
    localparam int LOWER_ROW_DIGITS = 13;
    localparam int MEMORY_BYTES     = 64;
    localparam int MEM_AW           = $clog2(MEMORY_BYTES);
    localparam int CALC_W           = 8;

    localparam logic [7:0] LO_KEEP0  = 8'h38;
    localparam logic [7:0] LO_KEEP1  = 8'h78;
    localparam logic [7:0] LO_KEEP2  = 8'h71;
    localparam logic [7:0] UP_KEEP0  = 8'h07;
    localparam logic [7:0] UP_KEEP1  = 8'h47;
    localparam logic [7:0] UP_KEEP2  = 8'h0F;
    localparam logic [7:0] LO_DOT    = 8'h04;
    localparam logic [7:0] LO_COMMA  = 8'h0C;
    localparam logic [7:0] UP_DOT    = 8'h20;
    localparam logic [7:0] UP_COMMA  = 8'h60;
    localparam logic [6:0] CODE_LINE = 7'h08;
    localparam logic [6:0] CODE_DASH = 7'h10;
    localparam logic [6:0] CODE_NONE = 7'h00;
    localparam logic [6:0] CODE_BAD  = 7'h18;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [1:0] SEL_B0 = 2'd0;
    localparam logic [1:0] SEL_B1 = 2'd1;
    localparam logic [1:0] SEL_B2 = 2'd2;

    typedef enum logic [1:0] {
        K_PUT  = 2'd0,
        K_FILL = 2'd1,
        K_READ = 2'd2,
        K_NOP  = 2'd3
    } t_kind;

    typedef struct packed {
        logic load;
        logic fill;
        logic rd;
        logic wr;
        logic inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  put_ok;
        logic  is_read;
        logic  last;
        logic  out_free;
    } t_status;

    function automatic logic [6:0] num_code(input logic [3:0] i);
        logic [6:0] c;
        begin
            unique case (i)
                4'd0:    c = 7'h6F;
                4'd1:    c = 7'h60;
                4'd2:    c = 7'h5E;
                4'd3:    c = 7'h7C;
                4'd4:    c = 7'h71;
                4'd5:    c = 7'h3D;
                4'd6:    c = 7'h3F;
                4'd7:    c = 7'h69;
                4'd8:    c = 7'h7F;
                4'd9:    c = 7'h7D;
                default: c = CODE_BAD;
            endcase
            return c;
        end
    endfunction

    function automatic logic [6:0] alpha_code(input logic [4:0] i);
        logic [6:0] c;
        begin
            unique case (i)
                5'd0:    c = 7'h7B;
                5'd1:    c = 7'h37;
                5'd2:    c = 7'h0F;
                5'd3:    c = 7'h76;
                5'd4:    c = 7'h1F;
                5'd5:    c = 7'h1B;
                5'd6:    c = 7'h2F;
                5'd7:    c = 7'h73;
                5'd8:    c = 7'h20;
                5'd9:    c = 7'h66;
                5'd10:   c = 7'h13;
                5'd11:   c = 7'h07;
                5'd12:   c = 7'h3A;
                5'd13:   c = 7'h32;
                5'd14:   c = 7'h36;
                5'd15:   c = 7'h5B;
                5'd16:   c = 7'h79;
                5'd17:   c = 7'h12;
                5'd18:   c = 7'h3D;
                5'd19:   c = 7'h17;
                5'd20:   c = 7'h67;
                5'd21:   c = 7'h26;
                5'd22:   c = 7'h2E;
                5'd23:   c = 7'h1C;
                5'd24:   c = 7'h75;
                5'd25:   c = 7'h5E;
                default: c = CODE_BAD;
            endcase
            return c;
        end
    endfunction

    function automatic logic [6:0] char_to_code(input logic [7:0] ch);
        logic [7:0] d_off;
        logic [7:0] lc_off;
        logic [7:0] uc_off;
        logic [6:0] c;
        begin
            d_off  = ch - 8'h30;
            lc_off = ch - 8'h61;
            uc_off = ch - 8'h41;
            priority if (ch >= 8'h30 && ch <= 8'h39) c = num_code(d_off[3:0]);
            else if (ch >= 8'h61 && ch <= 8'h7A)     c = alpha_code(lc_off[4:0]);
            else if (ch >= 8'h41 && ch <= 8'h5A)     c = alpha_code(uc_off[4:0]);
            else if (ch == 8'h5F)                    c = CODE_LINE;
            else if (ch == 8'h2D)                    c = CODE_DASH;
            else if (ch == 8'h20)                    c = CODE_NONE;
            else if (ch == 8'h01)                    c = CODE_LINE;
            else if (ch == 8'h00)                    c = CODE_NONE;
            else                                     c = CODE_BAD;
            return c;
        end
    endfunction

    function automatic logic [7:0] merge_byte(
        input logic       lower,
        input logic [1:0] sel,
        input logic [6:0] c,
        input logic       point,
        input logic       comma,
        input logic [7:0] old
    );
        logic [7:0] b;
        begin
            unique case (sel)
                SEL_B0: b = lower ? ((old & LO_KEEP0) | {5'b0, c[2:0]})
                                  : ((old & UP_KEEP0) | {2'b0, c[2:0], 3'b0});
                SEL_B1: b = lower ? ((old & LO_KEEP1) | {5'b0, c[5:3]})
                                  : ((old & UP_KEEP1) | {2'b0, c[5:3], 3'b0});
                SEL_B2: begin
                    if (point) begin
                        b = lower ? (old | (comma ? LO_COMMA : LO_DOT))
                                  : (old | (comma ? UP_COMMA : UP_DOT));
                    end else begin
                        b = lower ? ((old & LO_KEEP2) | {6'b0, c[6], 1'b0})
                                  : ((old & UP_KEEP2) | {3'b0, c[6], 4'b0});
                    end
                end
                default: b = old;
            endcase
            return b;
        end
    endfunction

endpackage

>>> hdl/ssdrw_ctrl.sv
// ----------------------------------------------------------------------------
// ssdrw_ctrl
// Sequencer: accepts items and steps the datapath through the
// read-modify-write of each byte and the read response.
// ----------------------------------------------------------------------------
module ssdrw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssdrw_pkg::t_status i_status,
    output ssdrw_pkg::t_cmd    o_cmd
);
    import ssdrw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_WR   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_status.kind)
                        K_PUT: begin
                            if (i_status.put_ok) begin
                                o_cmd.load = 1'b1;
                                n_state    = S_RD;
                            end
                        end
                        K_FILL: o_cmd.fill = 1'b1;
                        K_READ: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = i_status.is_read ? S_OUT : S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                if (i_status.last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> hdl/ssdrw_dpath.sv
// ----------------------------------------------------------------------------
// ssdrw_dpath
// Segment memory with fill marks, character decode, byte merge and the
// output register.
// ----------------------------------------------------------------------------
module ssdrw_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssdrw_pkg::t_kind   i_kind,
    input  logic [4:0]         i_digit_position,
    input  logic [7:0]         i_character_code,
    input  logic [5:0]         i_byte_address,
    input  logic [7:0]         i_fill_byte,
    input  ssdrw_pkg::t_cmd    i_cmd,
    output ssdrw_pkg::t_status o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_read_byte
);
    import ssdrw_pkg::*;

    logic [7:0]        r_mem [MEMORY_BYTES];
    logic [MEMORY_BYTES-1:0] r_valid;
    logic [7:0]        r_fill;
    logic [7:0]        r_mem_q;
    logic              r_rd_hit;
    logic              r_rd_in;

    logic              r_is_read;
    logic              r_lower;
    logic              r_point;
    logic              r_comma;
    logic [6:0]        r_code;
    logic [CALC_W-1:0] r_base;
    logic [1:0]        r_idx;

    logic              r_out_valid;
    logic [7:0]        r_out_data;

    logic [CALC_W-1:0] pos_ext;
    logic              in_lower;
    logic [CALC_W-1:0] row_pos;
    logic              in_point;
    logic [CALC_W-1:0] cur_addr;
    logic              cur_in;
    logic [MEM_AW-1:0] cur_idx;
    logic [7:0]        rd_byte;
    logic [7:0]        wr_byte;

    assign pos_ext  = CALC_W'(i_digit_position);
    assign in_lower = pos_ext < CALC_W'(LOWER_ROW_DIGITS);
    assign row_pos  = in_lower ? pos_ext : (pos_ext - CALC_W'(LOWER_ROW_DIGITS));
    assign in_point = (i_character_code == CH_DOT) || (i_character_code == CH_COMMA);

    assign cur_addr = r_base + CALC_W'(r_idx);
    assign cur_in   = cur_addr < CALC_W'(MEMORY_BYTES);
    assign cur_idx  = cur_addr[MEM_AW-1:0];

    assign rd_byte  = r_rd_in ? (r_rd_hit ? r_mem_q : r_fill) : 8'h00;
    assign wr_byte  = merge_byte(r_lower, r_idx, r_code, r_point, r_comma, rd_byte);

    assign o_status.kind     = i_kind;
    assign o_status.put_ok   = pos_ext < CALC_W'(DIGIT_COUNT);
    assign o_status.is_read  = r_is_read;
    assign o_status.last     = (r_idx == SEL_B2);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read <= (i_kind == K_READ);
            r_lower   <= in_lower;
            r_point   <= in_point;
            r_comma   <= (i_character_code == CH_COMMA);
            r_code    <= char_to_code(i_character_code);
            if (i_kind == K_READ) begin
                r_base <= CALC_W'(i_byte_address);
                r_idx  <= SEL_B0;
            end else begin
                r_base <= (row_pos << 1) + row_pos;
                r_idx  <= in_point ? SEL_B2 : SEL_B0;
            end
        end else if (i_cmd.inc) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_mem_q  <= r_mem[cur_idx];
            r_rd_hit <= cur_in && r_valid[cur_idx];
            r_rd_in  <= cur_in;
        end
        if (i_cmd.wr && cur_in) begin
            r_mem[cur_idx] <= wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= 8'h00;
        end else if (i_cmd.fill) begin
            r_valid <= '0;
            r_fill  <= i_fill_byte;
        end else if (i_cmd.wr && cur_in) begin
            r_valid[cur_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= rd_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_out_data;

endmodule

>>> hdl/seven_segment_display_ram_writer_core.sv
// ----------------------------------------------------------------------------
// seven_segment_display_ram_writer_core
// Segment memory writer for a two-row 26-digit 7-segment LCD.
//
// Input stream (s_axis): tuser carries the kind (put, fill, read), tdata
// the digit, character, byte address and fill value. Output stream
// (m_axis): one item with the memory byte for each read.
// A put reads and then writes each byte of its digit on the single-port
// segment memory before the input is ready again (only the third byte for
// a dot or comma, none when the digit is out of range). A fill sets a fill
// value and clears the per-byte written marks. A read shows its item on
// m_axis and frees the input at the same time.
// The output register holds a result until taken; the input keeps
// accepting put and fill items meanwhile, and a second read waits in its
// final step until the output register is free.
// Reset clears the fill value and the per-byte written marks, so the whole
// memory reads as zero, and empties the output register.
// ----------------------------------------------------------------------------
module seven_segment_display_ram_writer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // digit_position, character_code, byte_address, fill_byte
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // read_byte
);
    import ssdrw_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_kind   kind;

    assign kind = t_kind'(s_axis_tuser);

    ssdrw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ssdrw_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (kind),
        .i_digit_position (s_axis_tdata[4:0]),
        .i_character_code (s_axis_tdata[12:5]),
        .i_byte_address   (s_axis_tdata[18:13]),
        .i_fill_byte      (s_axis_tdata[26:19]),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_read_byte      (m_axis_tdata)
    );

endmodule

>>> tb/seven_segment_display_ram_writer_core_test.sv
// ----------------------------------------------------------------------------
// seven_segment_display_ram_writer_core_test
// Drives put, fill, read and unused items into the segment memory writer.
// Each accepted put or fill updates a local copy of the segment memory, and every
// read queues the byte it should return. Returned bytes are checked in
// order. Both stream sides stall in random bursts, except near the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seven_segment_display_ram_writer_core_test;

    import ssdrw_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int TAIL_ITEMS   = 200;
    localparam int MODE_ITEMS   = 150;
    localparam int RANDOM_ITEMS = 1950;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CURSOR = 8'h01;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LINE   = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    // segment glyphs, index 0 in the lowest bits
    localparam logic [69:0] NUM_GLYPHS = {
        7'h7D, 7'h7F, 7'h69, 7'h3F, 7'h3D, 7'h71, 7'h7C, 7'h5E, 7'h60, 7'h6F
    };
    localparam logic [181:0] ALPHA_GLYPHS = {
        7'h5E, 7'h75, 7'h1C, 7'h2E, 7'h26, 7'h67, 7'h17, 7'h3D, 7'h12,
        7'h79, 7'h5B, 7'h36, 7'h32, 7'h3A, 7'h07, 7'h13, 7'h66, 7'h20,
        7'h73, 7'h2F, 7'h1B, 7'h1F, 7'h76, 7'h0F, 7'h37, 7'h7B
    };

    typedef struct packed {
        t_kind      kind;
        logic [4:0] digit;
        logic [7:0] ch;
        logic [5:0] addr;
        logic [7:0] fill;
    } lcd_item_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = '0;   // digit_position, character_code, byte_address, fill_byte
    logic [1:0]  s_axis_tuser  = '0;   // kind
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;         // read_byte

    logic [7:0] seg_mem [MEMORY_BYTES];
    lcd_item_t  pending_items [$];
    lcd_item_t  shown_item;
    logic [7:0] read_bytes_due [$];
    logic [7:0] due_byte;

    int   total_items    = 0;
    int   items_taken    = 0;
    int   puts_seen      = 0;
    int   fills_seen     = 0;
    int   reads_checked  = 0;
    int   mismatches     = 0;
    int   idle_cycles    = 0;
    int   gap_left       = 0;
    int   send_idle_pct  = 25;
    int   stall_left     = 0;
    int   recv_stall_pct = 25;
    logic quiet_tail     = 1'b0;

    seven_segment_display_ram_writer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [6:0] glyph_of(input logic [7:0] ch);
        int idx;
        idx = 0;
        if (ch >= "0" && ch <= "9") begin
            idx = int'(ch) - 'h30;
            return NUM_GLYPHS[idx * 7 +: 7];
        end
        if (ch >= "a" && ch <= "z") begin
            idx = int'(ch) - 'h61;
            return ALPHA_GLYPHS[idx * 7 +: 7];
        end
        if (ch >= "A" && ch <= "Z") begin
            idx = int'(ch) - 'h41;
            return ALPHA_GLYPHS[idx * 7 +: 7];
        end
        if (ch == CH_LINE || ch == CH_CURSOR) return 7'h08;
        if (ch == CH_DASH) return 7'h10;
        if (ch == CH_SPACE || ch == CH_NUL) return 7'h00;
        return 7'h18;
    endfunction

    task automatic merge_into(input int a, input logic [7:0] keep, input logic [7:0] set);
        if (a < MEMORY_BYTES) seg_mem[MEM_AW'(a)] = (seg_mem[MEM_AW'(a)] & keep) | set;
    endtask

    task automatic put_glyph(input logic [4:0] digit, input logic [7:0] ch);
        int         base;
        logic       lower;
        logic [6:0] c;
        if (digit < DIGIT_COUNT) begin
            lower = digit < LOWER_ROW_DIGITS;
            base  = lower ? digit * 3 : (digit - LOWER_ROW_DIGITS) * 3;
            c     = glyph_of(ch);
            if (ch == CH_DOT) begin
                merge_into(base + 2, 8'hFF, lower ? LO_DOT : UP_DOT);
            end else if (ch == CH_COMMA) begin
                merge_into(base + 2, 8'hFF, lower ? LO_COMMA : UP_COMMA);
            end else if (lower) begin
                merge_into(base,     LO_KEEP0, {5'b0, c[2:0]});
                merge_into(base + 1, LO_KEEP1, {5'b0, c[5:3]});
                merge_into(base + 2, LO_KEEP2, {6'b0, c[6], 1'b0});
            end else begin
                merge_into(base,     UP_KEEP0, {2'b0, c[2:0], 3'b0});
                merge_into(base + 1, UP_KEEP1, {2'b0, c[5:3], 3'b0});
                merge_into(base + 2, UP_KEEP2, {3'b0, c[6], 4'b0});
            end
        end
    endtask

    task automatic apply_item(input lcd_item_t it);
        int i;
        case (it.kind)
            K_PUT: begin
                puts_seen++;
                put_glyph(it.digit, it.ch);
            end
            K_FILL: begin
                fills_seen++;
                for (i = 0; i < MEMORY_BYTES; i++) seg_mem[MEM_AW'(i)] = it.fill;
            end
            K_READ: begin
                read_bytes_due.push_back((it.addr < MEMORY_BYTES) ? seg_mem[it.addr] : 8'h00);
            end
            default: begin
            end
        endcase
    endtask

    // negative arguments get random content
    task automatic queue_item(input t_kind kind, input int digit, input int ch,
                              input int addr, input int fill);
        lcd_item_t it;
        it.kind  = kind;
        it.digit = (digit < 0) ? 5'($urandom) : 5'(digit);
        it.ch    = (ch < 0)    ? 8'($urandom) : 8'(ch);
        it.addr  = (addr < 0)  ? 6'($urandom) : 6'(addr);
        it.fill  = (fill < 0)  ? 8'($urandom) : 8'(fill);
        pending_items.push_back(it);
    endtask

    function automatic int rand_char();
        int k;
        k = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                k = $urandom_range(0, 61);
                if (k < 10) return 'h30 + k;
                if (k < 36) return 'h61 + k - 10;
                return 'h41 + k - 36;
            end
            4: return ($urandom_range(0, 1) == 0) ? int'(CH_DOT) : int'(CH_COMMA);
            5, 6: begin
                case ($urandom_range(0, 5))
                    0: return int'(CH_NUL);
                    1: return int'(CH_CURSOR);
                    2: return int'(CH_SPACE);
                    3: return int'(CH_LINE);
                    4: return int'(CH_DASH);
                    default: return $urandom_range(128, 255);
                endcase
            end
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(shown_item);
                items_taken++;
                if (items_taken % MODE_ITEMS == 0) begin
                    case ($urandom_range(0, 3))
                        0: send_idle_pct = 0;
                        1: send_idle_pct = 5;
                        2: send_idle_pct = 25;
                        default: send_idle_pct = 60;
                    endcase
                end
                quiet_tail <= (items_taken >= total_items - TAIL_ITEMS);
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left == 0 && !quiet_tail && pending_items.size() != 0 &&
                    $urandom_range(0, 99) < send_idle_pct) begin
                    gap_left = $urandom_range(1, 17);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    shown_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, shown_item.fill, shown_item.addr,
                                      shown_item.ch, shown_item.digit};
                    s_axis_tuser  <= shown_item.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                reads_checked++;
                if (read_bytes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: read byte with nothing expected, actual %02h",
                             $time, m_axis_tdata);
                end else begin
                    due_byte = read_bytes_due.pop_front();
                    if (m_axis_tdata !== due_byte) begin
                        mismatches++;
                        $display("%0t: read byte mismatch, expected %02h actual %02h",
                                 $time, due_byte, m_axis_tdata);
                    end
                end
                if (reads_checked % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: recv_stall_pct = 0;
                        1: recv_stall_pct = 10;
                        default: recv_stall_pct = 40;
                    endcase
                end
            end
            if (stall_left == 0 && !quiet_tail && $urandom_range(0, 99) < recv_stall_pct) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("seven_segment_display_ram_writer_core_test failed");
                $finish;
            end
        end
    end

    initial begin
        int i;
        int r;

        // memory starts out all zero
        for (i = 0; i < MEMORY_BYTES; i++) seg_mem[MEM_AW'(i)] = 8'h00;

        // directed: row overlap, dot and comma, special glyphs, ignored digits
        queue_item(K_READ, -1, -1, 0, -1);
        queue_item(K_FILL, -1, -1, -1, 'hFF);
        queue_item(K_PUT, 0, "8", -1, -1);
        queue_item(K_PUT, 13, "a", -1, -1);
        queue_item(K_PUT, 12, "Z", -1, -1);
        queue_item(K_PUT, 25, "m", -1, -1);
        queue_item(K_PUT, 0, int'(CH_DOT), -1, -1);
        queue_item(K_PUT, 13, int'(CH_COMMA), -1, -1);
        queue_item(K_READ, -1, -1, 0, -1);
        queue_item(K_READ, -1, -1, 1, -1);
        queue_item(K_READ, -1, -1, 2, -1);
        queue_item(K_READ, -1, -1, 38, -1);
        queue_item(K_PUT, 26, "A", -1, -1);
        queue_item(K_PUT, 31, "0", -1, -1);
        queue_item(K_PUT, 1, 'hFF, -1, -1);
        queue_item(K_PUT, 14, 'h80, -1, -1);
        queue_item(K_PUT, 2, int'(CH_NUL), -1, -1);
        queue_item(K_PUT, 15, int'(CH_CURSOR), -1, -1);
        queue_item(K_PUT, 3, int'(CH_LINE), -1, -1);
        queue_item(K_PUT, 16, int'(CH_DASH), -1, -1);
        queue_item(K_PUT, 4, int'(CH_SPACE), -1, -1);
        queue_item(K_NOP, -1, -1, -1, -1);
        queue_item(K_READ, -1, -1, 63, -1);
        queue_item(K_READ, -1, -1, 3, -1);
        queue_item(K_READ, -1, -1, 5, -1);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 52) begin
                queue_item(K_PUT,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31)
                                                       : $urandom_range(0, 25),
                           rand_char(), -1, -1);
            end else if (r < 92) begin
                queue_item(K_READ, -1, -1,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, 38), -1);
            end else if (r < 96) begin
                queue_item(K_FILL, -1, -1, -1, -1);
            end else begin
                queue_item(K_NOP, -1, -1, -1, -1);
            end
        end
        total_items = pending_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (read_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items: %0d puts, %0d fills, %0d read bytes checked",
                 items_taken, puts_seen, fills_seen, reads_checked);
        if (mismatches == 0) begin
            $display("seven_segment_display_ram_writer_core_test passed");
        end else begin
            $display("seven_segment_display_ram_writer_core_test failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/ssdrw_pkg.sv
hdl/ssdrw_ctrl.sv
hdl/ssdrw_dpath.sv
hdl/seven_segment_display_ram_writer_core.sv
tb/seven_segment_display_ram_writer_core_test.sv
